// ----- rtl/core/skcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial key command parser package
// Shared constants, codes, queue types and character helpers.
// ----------------------------------------------------------------------------
package skcp_pkg;

  // Line buffer size in bytes; one byte is kept back, so a line holds one less.
  localparam int LINE_BUFFER_BYTES = 40;
  localparam int LineCap           = LINE_BUFFER_BYTES - 1;
  localparam int LenW              = $clog2(LINE_BUFFER_BYTES);
  localparam int AddrW             = $clog2(LineCap);

  // Command queue between the classifier and the executor (power of two).
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int ByteW   = 8;
  localparam int CharW   = 7;
  localparam int EventW  = 3;
  localparam int KeyW    = 7;
  localparam int TokLenW = 4;
  localparam int ValW    = 10;
  localparam int AccW    = 14;
  localparam int WordW   = 56;

  localparam logic [TokLenW-1:0] TokLenSat = 4'd8;
  localparam logic [ValW-1:0]    ValSat    = 10'd1000;
  localparam logic [ValW-1:0]    KeyMax    = 10'd99;

  // Received byte codes.
  localparam logic [ByteW-1:0] ChCr         = 8'h0D;
  localparam logic [ByteW-1:0] ChLf         = 8'h0A;
  localparam logic [ByteW-1:0] ChBs         = 8'h08;
  localparam logic [ByteW-1:0] ChDel        = 8'h7F;
  localparam logic [ByteW-1:0] ChFirstPrint = 8'h20;
  localparam logic [ByteW-1:0] ChLastPrint  = 8'h7E;

  // Stored character codes.
  localparam logic [CharW-1:0] ChSpace = 7'h20;
  localparam logic [CharW-1:0] ChPlus  = 7'h2B;
  localparam logic [CharW-1:0] ChMinus = 7'h2D;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChNine  = 7'h39;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;
  localparam logic [CharW-1:0] ChLowZ  = 7'h7A;
  localparam logic [CharW-1:0] CaseGap = 7'h20;

  // Command words, left aligned, first character in the top byte.
  localparam logic [WordW-1:0] WordPing    = {"PING", 24'h0};
  localparam logic [WordW-1:0] WordHelp    = {"HELP", 24'h0};
  localparam logic [WordW-1:0] WordPress   = {"PRESS", 16'h0};
  localparam logic [WordW-1:0] WordRelease = "RELEASE";

  localparam logic [TokLenW-1:0] LenPing    = 4'd4;
  localparam logic [TokLenW-1:0] LenHelp    = 4'd4;
  localparam logic [TokLenW-1:0] LenPress   = 4'd5;
  localparam logic [TokLenW-1:0] LenRelease = 4'd7;
  localparam logic [TokLenW-1:0] LenShort   = 4'd1;

  typedef enum logic [EventW-1:0] {
    EV_PONG    = 3'd0,
    EV_HELP    = 3'd1,
    EV_PRESS   = 3'd2,
    EV_RELEASE = 3'd3,
    EV_UNKNOWN = 3'd4,
    EV_BADID   = 3'd5,
    EV_TOOLONG = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_BKSP   = 2'd1,
    OP_EOL    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } back_state_e;

  // Where the line walk stands relative to the first two tokens.
  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_CMD  = 3'd1,
    PH_GAP  = 3'd2,
    PH_ARG  = 3'd3,
    PH_REST = 3'd4
  } phase_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  function automatic logic [CharW-1:0] upcase(input logic [CharW-1:0] c);
    if (c >= ChLowA && c <= ChLowZ) begin
      return c - CaseGap;
    end
    return c;
  endfunction

  // True when character k of the token still matches the command word.
  function automatic logic word_char_ok(input logic [WordW-1:0]   word,
                                        input logic [TokLenW-1:0] wlen,
                                        input logic [TokLenW-1:0] k,
                                        input logic [CharW-1:0]   c);
    logic [WordW-1:0] sh;
    sh = word << {k[2:0], 3'b000};
    return (k < wlen) && (sh[WordW-1 -: ByteW] == {1'b0, upcase(c)});
  endfunction

endpackage

// ----- rtl/core/skcp_rx_if.sv -----
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one received byte per word.
// ----------------------------------------------------------------------------
interface skcp_rx_if;
  import skcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/skcp_ev_if.sv -----
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one parser event and key number per word.
// ----------------------------------------------------------------------------
interface skcp_ev_if;
  import skcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [KeyW-1:0]   key_id;

  modport source (output valid, output event_res, output key_id, input ready);
  modport sink   (input valid, input event_res, input key_id, output ready);
endinterface

// ----- rtl/core/serial_key_command_parser.sv -----
// ----------------------------------------------------------------------------
// Serial key command parser
// Line editor and command decoder for a byte stream from a serial receiver.
// ----------------------------------------------------------------------------
// An edit byte is classified, held in the queue and retired by the executor
// once it is idle; on a line end the executor reads the buffered line, one
// line-memory read a cycle, walks it and, unless the line is blank, loads its event.
// Throughput: one byte per cycle for edits while the queue has room; while a
// line end keeps the executor busy, the two-word queue absorbs further bytes.
// Reset: queue empty, line empty, no event pending; line memory is not cleared.
module serial_key_command_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  skcp_rx_if.sink   rx_i,
  skcp_ev_if.source ev_o
);
  import skcp_pkg::*;

  // The front end only classifies. Printable bytes become appends, backspace
  // and delete become erases, CR and LF become line ends, and every other
  // byte is accepted and dropped without touching the queue.
  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  skcp_front u_front (
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  // The queue lets the receiver keep sending while the executor walks a line.
  skcp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // The executor owns the line memory and the length counter. On a line end
  // it reads the line one character a cycle, tracks the command token against
  // the known words and accumulates the key number, then, unless the line holds
  // only spaces, loads one event word into its output register. An append at a
  // full line resets the line and emits the too-long event instead.
  skcp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .ev_o   (ev_o)
  );

endmodule

// ----- rtl/core/skcp_front.sv -----
// ----------------------------------------------------------------------------
// Byte classifier
// Sorts received bytes into append, erase and end-of-line commands.
// ----------------------------------------------------------------------------
module skcp_front (
  skcp_rx_if.sink          rx_i,
  input  logic             q_full_i,
  output skcp_pkg::q_push_t push_o
);
  import skcp_pkg::*;

  logic keep;
  op_e  op;

  // Bytes that carry no meaning are taken and dropped right here.
  always_comb begin
    keep = 1'b1;
    op   = OP_APPEND;
    priority if (rx_i.rx_byte == ChCr || rx_i.rx_byte == ChLf) begin
      op = OP_EOL;
    end else if (rx_i.rx_byte == ChBs || rx_i.rx_byte == ChDel) begin
      op = OP_BKSP;
    end else if (rx_i.rx_byte >= ChFirstPrint && rx_i.rx_byte <= ChLastPrint) begin
      op = OP_APPEND;
    end else begin
      keep = 1'b0;
    end
  end

  assign rx_i.ready     = !q_full_i;
  assign push_o.valid   = rx_i.valid && !q_full_i && keep;
  assign push_o.entry.op = op;
  assign push_o.entry.ch = rx_i.rx_byte[CharW-1:0];

endmodule

// ----- rtl/core/skcp_queue.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the classifier and the executor.
// ----------------------------------------------------------------------------
module skcp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skcp_pkg::q_push_t push_i,
  input  logic              pop_i,
  output logic              full_o,
  output skcp_pkg::q_head_t head_o
);
  import skcp_pkg::*;

  q_entry_t         slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push_en;
  logic             pop_en;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  assign push_en = push_i.valid && !full_o;
  assign pop_en  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = push_en ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_en ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_en && !pop_en) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_en && pop_en) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ----- rtl/core/skcp_back.sv -----
// ----------------------------------------------------------------------------
// Line executor
// Keeps the line buffer, walks it on end of line and issues events.
// ----------------------------------------------------------------------------
module skcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skcp_pkg::q_head_t head_i,
  output logic              pop_o,
  skcp_ev_if.source         ev_o
);
  import skcp_pkg::*;

  back_state_e state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic             dv_q, dv_d;
  logic [CharW-1:0] rd_data_q;
  logic [CharW-1:0] mem_q [LineCap];
  logic             wr_en, rd_en;
  logic             slot_free;
  logic             load;
  logic             scan_init, scan_take;

  logic   vld_q, vld_d;
  event_e ev_q, ev_d;
  logic [KeyW-1:0] key_q, key_d;

  // Walk state.
  phase_e             phase_q, phase_s;
  logic [TokLenW-1:0] tok_len_q, tok_len_s;
  logic m_ping_q, m_help_q, m_press_q, m_rel_q;
  logic m_ping_s, m_help_s, m_press_s, m_rel_s;
  logic first_q, neg_q, dig_q, bad_q;
  logic first_s, neg_s, dig_s, bad_s;
  logic [ValW-1:0] val_q, val_s;

  logic            is_sp, is_dig, is_sign, cmd_char, arg_char;
  logic [AccW-1:0] acc;

  logic   cmd_ping, cmd_help, cmd_press, cmd_rel, id_ok;
  event_e res_ev;

  assign slot_free = !vld_q || ev_o.ready;

  // One character of the walk.
  always_comb begin
    phase_s   = phase_q;
    tok_len_s = tok_len_q;
    m_ping_s  = m_ping_q;
    m_help_s  = m_help_q;
    m_press_s = m_press_q;
    m_rel_s   = m_rel_q;
    first_s   = first_q;
    neg_s     = neg_q;
    dig_s     = dig_q;
    bad_s     = bad_q;
    val_s     = val_q;
    cmd_char  = 1'b0;
    arg_char  = 1'b0;
    is_sp     = (rd_data_q == ChSpace);
    is_dig    = (rd_data_q >= ChZero) && (rd_data_q <= ChNine);
    is_sign   = (rd_data_q == ChPlus) || (rd_data_q == ChMinus);
    acc       = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1)
              + AccW'(rd_data_q - ChZero);

    unique case (phase_q)
      PH_LEAD: begin
        if (!is_sp) begin
          phase_s  = PH_CMD;
          cmd_char = 1'b1;
        end
      end
      PH_CMD: begin
        if (is_sp) phase_s = PH_GAP;
        else cmd_char = 1'b1;
      end
      PH_GAP: begin
        if (!is_sp) begin
          phase_s  = PH_ARG;
          arg_char = 1'b1;
        end
      end
      PH_ARG: begin
        if (is_sp) phase_s = PH_REST;
        else arg_char = 1'b1;
      end
      default: begin
      end
    endcase

    if (cmd_char) begin
      m_ping_s  = m_ping_q && word_char_ok(WordPing, LenPing, tok_len_q, rd_data_q);
      m_help_s  = m_help_q && word_char_ok(WordHelp, LenHelp, tok_len_q, rd_data_q);
      m_press_s = m_press_q && word_char_ok(WordPress, LenPress, tok_len_q, rd_data_q);
      m_rel_s   = m_rel_q && word_char_ok(WordRelease, LenRelease, tok_len_q, rd_data_q);
      tok_len_s = (tok_len_q == TokLenSat) ? TokLenSat : tok_len_q + TokLenW'(1);
    end

    if (arg_char) begin
      first_s = 1'b0;
      if (first_q && is_sign) begin
        neg_s = (rd_data_q == ChMinus);
      end else if (is_dig) begin
        dig_s = 1'b1;
        val_s = (acc > AccW'(ValSat)) ? ValSat : acc[ValW-1:0];
      end else begin
        bad_s = 1'b1;
      end
    end
  end

  // Decision at the end of the walk.
  always_comb begin
    cmd_ping  = m_ping_q && (tok_len_q == LenPing);
    cmd_help  = m_help_q && (tok_len_q == LenHelp);
    cmd_press = m_press_q && (tok_len_q == LenPress || tok_len_q == LenShort);
    cmd_rel   = m_rel_q && (tok_len_q == LenRelease || tok_len_q == LenShort);
    id_ok     = dig_q && !bad_q && !(neg_q && val_q != '0) && (val_q <= KeyMax);
    priority if (cmd_ping) begin
      res_ev = EV_PONG;
    end else if (cmd_help) begin
      res_ev = EV_HELP;
    end else if (!cmd_press && !cmd_rel) begin
      res_ev = EV_UNKNOWN;
    end else if (!id_ok) begin
      res_ev = EV_BADID;
    end else if (cmd_press) begin
      res_ev = EV_PRESS;
    end else begin
      res_ev = EV_RELEASE;
    end
  end

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    dv_d      = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    pop_o     = 1'b0;
    load      = 1'b0;
    scan_init = 1'b0;
    scan_take = 1'b0;
    ev_d      = ev_q;
    key_d     = key_q;
    vld_d     = vld_q && !ev_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.entry.op)
            OP_APPEND: begin
              if (len_q < LenW'(LineCap)) begin
                wr_en = 1'b1;
                len_d = len_q + LenW'(1);
                pop_o = 1'b1;
              end else if (slot_free) begin
                load  = 1'b1;
                ev_d  = EV_TOOLONG;
                key_d = '0;
                len_d = '0;
                pop_o = 1'b1;
              end
            end
            OP_BKSP: begin
              pop_o = 1'b1;
              if (len_q != '0) len_d = len_q - LenW'(1);
            end
            OP_EOL: begin
              pop_o = 1'b1;
              if (len_q != '0) begin
                scan_init = 1'b1;
                idx_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        scan_take = dv_q;
        if (idx_q < len_q) begin
          rd_en = 1'b1;
          dv_d  = 1'b1;
          idx_d = idx_q + LenW'(1);
        end else if (!dv_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (phase_q == PH_LEAD) begin
          len_d   = '0;
          state_d = ST_IDLE;
        end else if (slot_free) begin
          load    = 1'b1;
          ev_d    = res_ev;
          key_d   = (res_ev == EV_PRESS || res_ev == EV_RELEASE) ? val_q[KeyW-1:0] : '0;
          len_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      idx_q   <= '0;
      dv_q    <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      dv_q    <= dv_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    key_q <= key_d;
    if (scan_init) begin
      phase_q   <= PH_LEAD;
      tok_len_q <= '0;
      m_ping_q  <= 1'b1;
      m_help_q  <= 1'b1;
      m_press_q <= 1'b1;
      m_rel_q   <= 1'b1;
      first_q   <= 1'b1;
      neg_q     <= 1'b0;
      dig_q     <= 1'b0;
      bad_q     <= 1'b0;
      val_q     <= '0;
    end else if (scan_take) begin
      phase_q   <= phase_s;
      tok_len_q <= tok_len_s;
      m_ping_q  <= m_ping_s;
      m_help_q  <= m_help_s;
      m_press_q <= m_press_s;
      m_rel_q   <= m_rel_s;
      first_q   <= first_s;
      neg_q     <= neg_s;
      dig_q     <= dig_s;
      bad_q     <= bad_s;
      val_q     <= val_s;
    end
  end

  // Line memory: one write port for appends, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AddrW-1:0]] <= head_i.entry.ch;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[AddrW-1:0]];
    end
  end

  assign ev_o.valid     = vld_q;
  assign ev_o.event_res = ev_q;
  assign ev_o.key_id    = key_q;

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(LineCap))
    else $error("line length above capacity");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= len_q)
    else $error("walk index passed the line end");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && phase_q != PH_LEAD && slot_free)
      |=> (vld_q && len_q == '0 && state_q == ST_IDLE))
    else $error("finished line did not produce an event");

  a_key_only_for_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && key_q != '0) |-> (ev_q == EV_PRESS || ev_q == EV_RELEASE))
    else $error("key number on an event without a key");
`endif

endmodule
